// ===== hdl/elevator_stop_scheduler_defines.svh =====
`ifndef ELEVATOR_STOP_SCHEDULER_DEFINES_SVH
`define ELEVATOR_STOP_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define ESS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("elevator_stop_scheduler: check failed");

// Next-cycle implication, checked on clk_i outside reset.
`define ESS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("elevator_stop_scheduler: check failed");

`endif

// ===== hdl/elsc_pkg.sv =====
`default_nettype none

package elsc_pkg;

  localparam int FLOOR_COUNT = 16;
  localparam int FLOOR_W     = 5;
  localparam int IDX_W       = $clog2(FLOOR_COUNT);
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [1:0] {
    REQ_CALL   = 2'd0,
    REQ_ARRIVE = 2'd1,
    REQ_PASS   = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    HEAD_STAY = 2'd0,
    HEAD_UP   = 2'd1,
    HEAD_DOWN = 2'd2
  } head_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOW,
    ST_SCAN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic               start;
    logic [FLOOR_W-1:0] first;
    logic               up;
  } scan_cmd_t;

  typedef struct packed {
    logic               done;
    logic               found;
    logic [FLOOR_W-1:0] floor;
  } scan_res_t;

endpackage

`default_nettype wire

// ===== hdl/elsc_scan.sv =====
`default_nettype none

module elsc_scan (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire elsc_pkg::scan_cmd_t              cmd_i,
  input  wire logic [elsc_pkg::FLOOR_COUNT-1:0] pending_i,
  output elsc_pkg::scan_res_t                   res_o
);
  import elsc_pkg::*;

  logic               busy_q, busy_d;
  logic               up_q, up_d;
  logic [FLOOR_W-1:0] idx_q, idx_d;
  logic [FLOOR_W-1:0] idx_m1;
  logic               in_range;
  logic               hit;
  logic               done;

  assign in_range = (idx_q != '0) && (idx_q <= FLOOR_W'(FLOOR_COUNT));
  assign idx_m1   = idx_q - FLOOR_W'(1);
  assign hit      = in_range && pending_i[idx_m1[IDX_W-1:0]];
  assign done     = busy_q && (!in_range || hit);

  assign res_o.done  = done;
  assign res_o.found = hit;
  assign res_o.floor = idx_q;

  always_comb begin
    busy_d = busy_q;
    up_d   = up_q;
    idx_d  = idx_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      up_d   = cmd_i.up;
      idx_d  = cmd_i.first;
    end else if (busy_q) begin
      if (done) begin
        busy_d = 1'b0;
      end else if (up_q) begin
        idx_d = idx_q + FLOOR_W'(1);
      end else begin
        idx_d = idx_q - FLOOR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    up_q  <= up_d;
    idx_q <= idx_d;
  end

endmodule

`default_nettype wire

// ===== hdl/elevator_stop_scheduler.sv =====
// A call is accepted, then the floor scan runs from the current floor, then the result is offered.
// An arrival at the goal floor runs two scans: one for the lowest pending floor, then one for the stop.
// Throughput: one item at a time; s_axis_tready is high only while no item is in work.
// The floor scan unit tests one floor per cycle and is shared by both searches.
// Reset (rst_ni low, asynchronous): current floor 1, no goal, no pending calls, free, heading stay.
`default_nettype none
`include "elevator_stop_scheduler_defines.svh"

module elevator_stop_scheduler (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [elsc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [4:0] floor
  input  wire logic [elsc_pkg::IN_TUSER_W-1:0]     s_axis_tuser,  // [1:0] req_type
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [elsc_pkg::OUT_TDATA_W-1:0]         m_axis_tdata   // [4:0] next_stop, [5] going_down
);
  import elsc_pkg::*;

  state_e                 state_q, state_d;
  logic [FLOOR_W-1:0]     cur_q, cur_d;
  logic [FLOOR_W-1:0]     goal_q, goal_d;
  logic [FLOOR_COUNT-1:0] pend_q, pend_d;
  logic                   busy_q, busy_d;
  head_e                  head_q, head_d;
  logic                   call_q, call_d;
  logic [FLOOR_W-1:0]     flr_q, flr_d;
  logic [FLOOR_W-1:0]     stop_q, stop_d;
  logic                   down_q, down_d;

  logic                   acc;
  req_e                   req;
  logic [FLOOR_W-1:0]     in_floor;
  logic                   floor_ok;
  logic [FLOOR_W-1:0]     in_m1;
  logic [FLOOR_COUNT-1:0] floor_bit;
  logic [FLOOR_W-1:0]     goal_call;
  logic [FLOOR_W-1:0]     goal_low;
  scan_cmd_t              scan_cmd;
  scan_res_t              scan_res;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign req           = req_e'(s_axis_tuser);
  assign in_floor      = s_axis_tdata[FLOOR_W-1:0];
  assign floor_ok      = (in_floor != '0) && (in_floor <= FLOOR_W'(FLOOR_COUNT));
  assign in_m1         = in_floor - FLOOR_W'(1);
  assign floor_bit     = {{(FLOOR_COUNT-1){1'b0}}, 1'b1} << in_m1[IDX_W-1:0];
  assign goal_low      = scan_res.found ? scan_res.floor : '0;

  // Push the goal outward along the heading on a call.
  always_comb begin
    goal_call = (goal_q == '0) ? in_floor : goal_q;
    if (((head_q == HEAD_UP) && (in_floor > goal_call)) ||
        ((head_q == HEAD_DOWN) && (in_floor < goal_call))) begin
      goal_call = in_floor;
    end
  end

  elsc_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (scan_cmd),
    .pending_i(pend_q),
    .res_o    (scan_res)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc && floor_ok) begin
          case (req)
            REQ_CALL: state_d = ST_SCAN;
            REQ_ARRIVE: begin
              if (busy_q) begin
                state_d = (in_floor == goal_q) ? ST_LOW : ST_SCAN;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOW: begin
        if (scan_res.done) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          state_d = (scan_res.found || call_q) ? ST_OUT : ST_IDLE;
        end
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and scan control
  always_comb begin
    cur_d    = cur_q;
    goal_d   = goal_q;
    pend_d   = pend_q;
    busy_d   = busy_q;
    head_d   = head_q;
    call_d   = call_q;
    flr_d    = flr_q;
    stop_d   = stop_q;
    down_d   = down_q;
    scan_cmd = '0;
    case (state_q)
      ST_IDLE: begin
        if (acc && floor_ok) begin
          case (req)
            REQ_CALL: begin
              busy_d         = 1'b1;
              pend_d         = pend_q | floor_bit;
              goal_d         = goal_call;
              call_d         = 1'b1;
              flr_d          = in_floor;
              scan_cmd.start = 1'b1;
              scan_cmd.first = cur_q;
              scan_cmd.up    = goal_call > cur_q;
            end
            REQ_ARRIVE: begin
              if (busy_q) begin
                cur_d  = in_floor;
                pend_d = pend_q & ~floor_bit;
                call_d = 1'b0;
                flr_d  = in_floor;
                scan_cmd.start = 1'b1;
                if (in_floor == goal_q) begin
                  // find the lowest pending floor first
                  scan_cmd.first = FLOOR_W'(1);
                  scan_cmd.up    = 1'b1;
                end else begin
                  scan_cmd.first = in_floor;
                  scan_cmd.up    = goal_q > in_floor;
                end
              end
            end
            REQ_PASS: cur_d = in_floor;
            default: cur_d = cur_q;
          endcase
        end
      end
      ST_LOW: begin
        if (scan_res.done) begin
          goal_d         = goal_low;
          scan_cmd.start = 1'b1;
          scan_cmd.first = cur_q;
          scan_cmd.up    = goal_low > cur_q;
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          if (scan_res.found || call_q) begin
            stop_d = scan_res.found ? scan_res.floor : flr_q;
            down_d = cur_q > goal_q;
            head_d = (cur_q > goal_q) ? HEAD_DOWN : HEAD_UP;
          end else begin
            busy_d = 1'b0;
          end
        end
      end
      default: busy_d = busy_q;
    endcase
  end

  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {{(OUT_TDATA_W-FLOOR_W-1){1'b0}}, down_q, stop_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cur_q   <= FLOOR_W'(1);
      goal_q  <= '0;
      pend_q  <= '0;
      busy_q  <= 1'b0;
      head_q  <= HEAD_STAY;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      goal_q  <= goal_d;
      pend_q  <= pend_d;
      busy_q  <= busy_d;
      head_q  <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    call_q <= call_d;
    flr_q  <= flr_d;
    stop_q <= stop_d;
    down_q <= down_d;
  end

  `ESS_ASSERT_IMP(a_one_item, m_axis_tvalid, !s_axis_tready)
  `ESS_ASSERT_IMP(a_out_busy, m_axis_tvalid, busy_q)
  `ESS_ASSERT_IMP(a_stop_range, m_axis_tvalid,
                  (stop_q != '0) && (stop_q <= FLOOR_W'(FLOOR_COUNT)))
  `ESS_ASSERT_IMP(a_scan_owner, scan_res.done, (state_q == ST_LOW) || (state_q == ST_SCAN))
  `ESS_ASSERT_NXT(a_call_busy, acc && floor_ok && (req == REQ_CALL), busy_q)

endmodule

`default_nettype wire
